// ===== design/crrs_pkg.sv =====
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared constants and the quarter-wave cosine table for the cosine
// restart rate schedule.
// ----------------------------------------------------------------------------
package crrs_pkg;

    localparam int EPOCH_FRAC_BITS   = 8;
    localparam int RATE_FRAC_BITS    = 24;
    localparam int COS_TABLE_ENTRIES = 1024;
    localparam int COS_ADDR_W        = $clog2(COS_TABLE_ENTRIES);
    // phase q is Q32 of a half turn; table steps in Q16 are q * 2N >> 16
    localparam int PHASE_SHIFT       = 16 - (COS_ADDR_W + 1);

    localparam logic [23:0] LEN_MAX  = 24'hFFFFFF;
    localparam logic [24:0] COS_ONE  = 25'h0800000;

    localparam logic [63:0] Q30_ONE  = 64'h40000000;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;

    localparam logic [1:0] REG_START_RATE    = 2'd0;
    localparam logic [1:0] REG_FLOOR_RATE    = 2'd1;
    localparam logic [1:0] REG_BASE_PERIOD   = 2'd2;
    localparam logic [1:0] REG_PERIOD_GROWTH = 2'd3;

    typedef logic [23:0] cos_tab_t [COS_TABLE_ENTRIES];
    typedef logic [7:0]  horner_t  [7];

    localparam horner_t HORNER_DIV = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // Taylor series in Q30, Horner form, truncating; rounded to Q23
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] a;
        logic [63:0] m;
        logic [63:0] v;
        for (int k = 0; k < COS_TABLE_ENTRIES; k++)
        begin
            x  = (64'(k) * PI_Q30) >> (COS_ADDR_W + 1);
            x2 = (x * x) >> 30;
            a  = Q30_ONE;
            for (int s = 0; s < 7; s++)
            begin
                m = ((x2 * a) >> 30) / 64'(HORNER_DIV[s]);
                a = (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
            end
            v = (a + 64'd64) >> 7;
            tab[k] = (v > 64'(COS_ONE)) ? 24'(COS_ONE) : v[23:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ===== design/cosine_restart_rate_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// cosine_restart_rate_schedule_unit
// Cosine-annealing learning-rate schedule with warm restarts, built around
// one shared restoring divider and a small sequencer.
// ----------------------------------------------------------------------------
// One input transfer either advances the schedule by one epoch (mode 0) or
// jumps to target_epoch (mode 1, Q24.8). The unit takes one item at a time:
// in_ready is high only when the sequencer is idle, and the result stays on
// the output until its transfer completes. An advance runs through the
// 32-step restoring divider that forms the cosine phase pos/len, then the
// table read, interpolation and final multiply. A jump past the first
// cycle with period_growth of 1 first uses the same divider to compute
// target mod base. A jump past the first cycle with larger growth first
// sums cycle lengths until the target falls inside one (lengths at least
// double until they saturate). Configuration transfers are accepted
// only while the sequencer is idle (cfg_ready low otherwise); writing
// base_period restarts the current cycle at position 0. The rate is
// floor + (start - floor) * (1 + cos(pi*pos/len)) / 2 in Q8.24, using a
// 1024-entry quarter-wave table with linear interpolation.
// ----------------------------------------------------------------------------
module cosine_restart_rate_schedule_unit
    import crrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] target_epoch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] rate,
    output logic [31:0] position,
    output logic [23:0] period,
    output logic [23:0] epoch_now,
    output logic        saturated
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_DINIT = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_TAB   = 4'd5;
    localparam logic [3:0] S_RD0   = 4'd6;
    localparam logic [3:0] S_RD1   = 4'd7;
    localparam logic [3:0] S_RD2   = 4'd8;
    localparam logic [3:0] S_INT   = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // configuration
    logic [31:0] start_rate_reg;
    logic [31:0] floor_rate_reg;
    logic [23:0] base_period_reg;
    logic [4:0]  period_growth_reg;

    // schedule state
    logic [31:0] pos_reg;
    logic [23:0] len_reg;
    logic [23:0] epoch_reg;

    // sequencer and datapath
    logic [3:0]  state_reg;
    logic [31:0] t_reg;
    logic        mode_reg;
    logic        sat_reg;
    logic        mod_phase_reg;
    logic [31:0] sum_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] div_reg;
    logic [4:0]  cnt_reg;
    logic [COS_ADDR_W:0]   idx_reg;
    logic [15:0] frac_reg;
    logic        neg_reg;
    logic [COS_ADDR_W-1:0] tab_addr_reg;
    logic [23:0] tab_data_reg;
    logic [23:0] v0_reg;
    logic signed [41:0] iprod_reg;
    logic [24:0] h_reg;
    logic [56:0] rprod_reg;
    logic [31:0] rate_reg;

    // effective base period and growth
    logic [23:0] base_eff;
    logic [4:0]  grow_eff;
    assign base_eff = (base_period_reg == 24'd0) ? 24'd1 : base_period_reg;
    assign grow_eff = (period_growth_reg == 5'd0) ? 5'd1 :
                      (period_growth_reg > 5'd16) ? 5'd16 : period_growth_reg;

    logic [31:0] len_d;
    logic [31:0] base_d;
    assign len_d  = {len_reg, 8'd0};
    assign base_d = {base_eff, 8'd0};

    // length growth with saturation
    logic [28:0] grown;
    logic [23:0] grown_len;
    logic        grown_sat;
    assign grown     = 29'(len_reg) * 29'(grow_eff);
    assign grown_sat = (grown > 29'(LEN_MAX));
    assign grown_len = grown_sat ? LEN_MAX : grown[23:0];

    // advance
    logic [32:0] adv_pos;
    assign adv_pos = 33'(pos_reg) + 33'(1 << EPOCH_FRAC_BITS);

    // cycle search
    logic [32:0] next_sum;
    assign next_sum = 33'(sum_reg) + 33'(len_d);

    // shared restoring divider step
    logic [32:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg, dvd_reg[31]};
    assign q_bit  = (rem_sh >= 33'(div_reg));

    // phase to table index
    logic [27:0] s16;
    logic [26:0] pp;
    logic        pp_neg;
    assign s16    = 28'(dvd_reg >> PHASE_SHIFT);
    assign pp_neg = (s16 > (28'(COS_TABLE_ENTRIES) << 16));
    assign pp     = pp_neg ? 27'((28'(COS_TABLE_ENTRIES) << 17) - s16) : s16[26:0];

    // interpolation
    logic        idx_out;
    logic        idx_last;
    logic [23:0] v1;
    logic signed [41:0] acc;
    logic [41:0] acc_rnd;
    logic [23:0] cval;
    assign idx_out  = (idx_reg >= (COS_ADDR_W+1)'(COS_TABLE_ENTRIES));
    assign idx_last = (idx_reg >= (COS_ADDR_W+1)'(COS_TABLE_ENTRIES - 1));
    assign v1       = idx_last ? 24'd0 : tab_data_reg;
    assign acc      = $signed({2'b00, v0_reg, 16'd0}) + iprod_reg;
    assign acc_rnd  = 42'(acc) + 42'd32768;
    assign cval     = (idx_out || acc < 0) ? 24'd0 : acc_rnd[39:16];

    logic        up;
    logic [31:0] diff;
    logic [56:0] rprod_rnd;
    assign up        = (start_rate_reg >= floor_rate_reg);
    assign diff      = up ? start_rate_reg - floor_rate_reg : floor_rate_reg - start_rate_reg;
    assign rprod_rnd = rprod_reg + 57'(1 << (RATE_FRAC_BITS - 1));

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign rate      = rate_reg;
    assign position  = pos_reg;
    assign period    = len_reg;
    assign epoch_now = epoch_reg;
    assign saturated = sat_reg;

    // registered cosine table read
    always_ff @(posedge clk)
    begin
        tab_data_reg <= COS_TAB[tab_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rate_reg    <= 32'd16777216;
            floor_rate_reg    <= 32'd0;
            base_period_reg   <= 24'd10;
            period_growth_reg <= 5'd1;
            pos_reg           <= 32'd0;
            len_reg           <= 24'd10;
            epoch_reg         <= 24'd0;
            state_reg         <= S_IDLE;
            sat_reg           <= 1'b0;
            mod_phase_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    4'(REG_START_RATE):    start_rate_reg <= cfg_data;
                    4'(REG_FLOOR_RATE):    floor_rate_reg <= cfg_data;
                    4'(REG_BASE_PERIOD):
                    begin
                        base_period_reg <= cfg_data[23:0];
                        len_reg         <= (cfg_data[23:0] == 24'd0) ? 24'd1 : cfg_data[23:0];
                        pos_reg         <= 32'd0;
                    end
                    4'(REG_PERIOD_GROWTH): period_growth_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        t_reg     <= target_epoch;
                        sat_reg   <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (!mode_reg)
                    begin
                        if (adv_pos >= 33'(len_d))
                        begin
                            pos_reg <= 32'(adv_pos - 33'(len_d));
                            len_reg <= grown_len;
                            if (grown_sat)
                                sat_reg <= 1'b1;
                        end
                        else
                            pos_reg <= adv_pos[31:0];
                        if (epoch_reg == LEN_MAX)
                            sat_reg <= 1'b1;
                        else
                            epoch_reg <= epoch_reg + 24'd1;
                        state_reg <= S_DINIT;
                    end
                    else
                    begin
                        epoch_reg <= t_reg[31:EPOCH_FRAC_BITS];
                        len_reg   <= base_eff;
                        if (t_reg < base_d)
                        begin
                            pos_reg   <= t_reg;
                            state_reg <= S_DINIT;
                        end
                        else if (grow_eff == 5'd1)
                        begin
                            rem_reg       <= 32'd0;
                            dvd_reg       <= t_reg;
                            div_reg       <= base_d;
                            cnt_reg       <= 5'd0;
                            mod_phase_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                        else
                        begin
                            sum_reg   <= 32'd0;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (33'(t_reg) >= next_sum)
                    begin
                        sum_reg <= next_sum[31:0];
                        len_reg <= grown_len;
                        if (grown_sat)
                            sat_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg   <= t_reg - sum_reg;
                        state_reg <= S_DINIT;
                    end
                end
                S_DINIT:
                begin
                    rem_reg   <= (pos_reg >= len_d) ? len_d - 32'd1 : pos_reg;
                    dvd_reg   <= 32'd0;
                    div_reg   <= len_d;
                    cnt_reg   <= 5'd0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= q_bit ? 32'(rem_sh - 33'(div_reg)) : rem_sh[31:0];
                    dvd_reg <= {dvd_reg[30:0], q_bit};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        if (mod_phase_reg)
                        begin
                            // jump with unit growth: remainder is the position
                            pos_reg       <= q_bit ? 32'(rem_sh - 33'(div_reg)) : rem_sh[31:0];
                            mod_phase_reg <= 1'b0;
                            state_reg     <= S_DINIT;
                        end
                        else
                            state_reg <= S_TAB;
                    end
                end
                S_TAB:
                begin
                    idx_reg      <= pp[26:16];
                    frac_reg     <= pp[15:0];
                    neg_reg      <= pp_neg;
                    tab_addr_reg <= pp[16 +: COS_ADDR_W];
                    state_reg    <= S_RD0;
                end
                S_RD0:
                begin
                    tab_addr_reg <= idx_reg[COS_ADDR_W-1:0] + COS_ADDR_W'(1);
                    state_reg    <= S_RD1;
                end
                S_RD1:
                begin
                    v0_reg    <= tab_data_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    iprod_reg <= 42'(signed'({1'b0, v1}) - signed'({1'b0, v0_reg}))
                                 * 42'(signed'({1'b0, frac_reg}));
                    state_reg <= S_INT;
                end
                S_INT:
                begin
                    h_reg     <= neg_reg ? COS_ONE - 25'(cval) : COS_ONE + 25'(cval);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    rprod_reg <= 57'(diff) * 57'(h_reg);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    rate_reg  <= up ? floor_rate_reg + rprod_rnd[RATE_FRAC_BITS +: 32]
                                    : floor_rate_reg - rprod_rnd[RATE_FRAC_BITS +: 32];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cosine restart rate schedule unit. A directed
// table of steps and register writes is followed by random phases, each
// under a fresh register setting. Every result transfer is compared with a
// local model of the schedule.
// ----------------------------------------------------------------------------
module tb
    import crrs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // Kinds of rows in the directed table
    typedef enum logic [1:0] {ROW_STEP, ROW_CFG, ROW_STEP_KNOWN} row_kind_t;

    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] position;
        logic [23:0] period;
        logic [23:0] epoch_now;
        logic        saturated;
    } sched_out_t;

    typedef struct {
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [31:0] data;
        logic        mode;
        logic [31:0] target;
        sched_out_t  known;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [31:0] target_epoch = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] rate;
    logic [31:0] position;
    logic [23:0] period;
    logic [23:0] epoch_now;
    logic        saturated;

    always #4 clk = ~clk;

    cosine_restart_rate_schedule_unit u_dut (.*);

    // Model state: registers, cycle position/length, epoch count
    logic [31:0] m_start, m_floor;
    logic [23:0] m_base;
    logic [4:0]  m_growth;
    logic [63:0] m_pos;
    logic [23:0] m_len;
    logic [23:0] m_epoch;
    logic [23:0] cos_q23 [COS_TABLE_ENTRIES];

    sched_out_t rate_queue[$];
    int  mismatches = 0;
    bit  long_hold = 1'b0;
    int  idle_cycles = 0;

    // Quarter-wave table: Taylor series in Q30, Horner, rounded to Q23
    task automatic fill_cos_table();
        logic [63:0] x, x2, a, m, v;
        int dv [7] = '{182, 132, 90, 56, 30, 12, 2};
        for (int k = 0; k < COS_TABLE_ENTRIES; k++)
        begin
            x  = (64'(k) * 64'd3373259426) / (2 * COS_TABLE_ENTRIES);
            x2 = (x * x) >> 30;
            a  = 64'h40000000;
            for (int s = 0; s < 7; s++)
            begin
                m = ((x2 * a) >> 30) / 64'(dv[s]);
                a = (m >= 64'h40000000) ? 64'd0 : 64'h40000000 - m;
            end
            v = (a + 64'd64) >> 7;
            cos_q23[k] = (v > 64'h800000) ? 24'h800000 : v[23:0];
        end
    endtask

    function automatic logic [23:0] base_eff();
        return (m_base == 0) ? 24'd1 : m_base;
    endfunction

    function automatic logic [23:0] growth_eff();
        if (m_growth == 0) return 24'd1;
        return (m_growth > 16) ? 24'd16 : 24'(m_growth);
    endfunction

    function automatic logic [23:0] lengthen(logic [23:0] len, ref bit sat);
        logic [63:0] p;
        p = 64'(len) * 64'(growth_eff());
        if (p > 64'hFFFFFF)
        begin
            sat = 1'b1;
            return 24'hFFFFFF;
        end
        return p[23:0];
    endfunction

    // Interpolated cosine of pp table steps (Q16), result Q23
    function automatic longint quarter_cosine(logic [63:0] pp);
        logic [63:0] i;
        longint f, v0, v1, acc;
        i = pp >> 16;
        f = longint'(pp[15:0]);
        if (i >= COS_TABLE_ENTRIES) return 0;
        v0 = longint'(cos_q23[i]);
        v1 = (i + 1 < COS_TABLE_ENTRIES) ? longint'(cos_q23[i + 1]) : 0;
        acc = v0 * 65536 + (v1 - v0) * f;
        if (acc < 0) acc = 0;
        return longint'((64'(acc) + 64'd32768) >> 16);
    endfunction

    function automatic logic [31:0] scheduled_rate();
        logic [63:0] d, r, q, s16, h, span;
        longint c;
        d = 64'(m_len) << EPOCH_FRAC_BITS;
        r = m_pos;
        q = 0;
        if (r >= d) r = d - 1;
        for (int b = 0; b < 32; b++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        s16 = (q * (2 * COS_TABLE_ENTRIES)) >> 16;
        if (s16 <= (64'(COS_TABLE_ENTRIES) << 16))
            c = quarter_cosine(s16);
        else
            c = -quarter_cosine((64'(2 * COS_TABLE_ENTRIES) << 16) - s16);
        h = 64'(longint'(64'h800000) + c);
        if (m_start >= m_floor)
        begin
            span = 64'(m_start - m_floor);
            return m_floor + 32'((span * h + 64'h800000) >> 24);
        end
        span = 64'(m_floor - m_start);
        return m_floor - 32'((span * h + 64'h800000) >> 24);
    endfunction

    task automatic model_reset();
        m_start = 32'd16777216;
        m_floor = 0;
        m_base = 24'd10;
        m_growth = 5'd1;
        m_pos = 0;
        m_len = 24'd10;
        m_epoch = 0;
    endtask

    task automatic model_write(logic [3:0] idx, logic [31:0] data);
        case (idx)
            4'(REG_START_RATE):    m_start = data;
            4'(REG_FLOOR_RATE):    m_floor = data;
            4'(REG_BASE_PERIOD):
            begin
                m_base = data[23:0];
                m_len = base_eff();
                m_pos = 0;
            end
            4'(REG_PERIOD_GROWTH): m_growth = data[4:0];
            default: ;
        endcase
    endtask

    function automatic sched_out_t schedule_step(logic md, logic [31:0] tgt);
        sched_out_t o;
        bit sat;
        logic [63:0] d, t, bd, sum;
        logic [23:0] len;
        sat = 1'b0;
        if (!md)
        begin
            if (m_len == 0) m_len = base_eff();
            d = 64'(m_len) << EPOCH_FRAC_BITS;
            m_pos = m_pos + (64'd1 << EPOCH_FRAC_BITS);
            if (m_pos >= d)
            begin
                m_pos = m_pos - d;
                m_len = lengthen(m_len, sat);
            end
            if (m_epoch == 24'hFFFFFF) sat = 1'b1;
            else m_epoch = m_epoch + 1;
        end
        else
        begin
            t = 64'(tgt);
            bd = 64'(base_eff()) << EPOCH_FRAC_BITS;
            if (t < bd)
            begin
                m_len = base_eff();
                m_pos = t;
            end
            else if (growth_eff() == 1)
            begin
                m_len = base_eff();
                m_pos = t % bd;
            end
            else
            begin
                sum = 0;
                len = base_eff();
                while (t >= sum + (64'(len) << EPOCH_FRAC_BITS))
                begin
                    sum = sum + (64'(len) << EPOCH_FRAC_BITS);
                    len = lengthen(len, sat);
                end
                m_len = len;
                m_pos = t - sum;
            end
            // whole part of a Q24.8 32-bit value never exceeds 24 bits
            m_epoch = tgt[31:8];
        end
        o.rate = scheduled_rate();
        o.position = m_pos[31:0];
        o.period = m_len;
        o.epoch_now = m_epoch;
        o.saturated = sat;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Send one item in the burst/gap style; expectation queued at acceptance.
    // valid stays up between items of a burst and drops only for a gap or a register write.
    int burst_left = 0;
    task automatic send_item(logic md, logic [31:0] tgt, bit known_on, sched_out_t known);
        sched_out_t e;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        mode <= md;
        target_epoch <= tgt;
        do @(posedge clk); while (!in_ready);
        e = schedule_step(md, tgt);
        if (known_on && e != known)
            report_mismatch("table row", 64'(e), 64'(known));
        rate_queue.push_back(e);
    endtask

    // Write only once the unit has delivered everything and drained
    task automatic write_reg(logic [3:0] idx, logic [31:0] data);
        in_valid <= 1'b0;
        burst_left = 0;
        while (rate_queue.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        model_write(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_target();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4095);
            1: return $urandom_range(0, 65535);
            2: return {8'($urandom_range(0, 255)), 24'h0} | 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    // Receiver: stall pattern of its own, plus one long hold-off
    int hold_cnt = 0;
    always @(posedge clk)
    begin
        if (long_hold && hold_cnt < 300)
        begin
            hold_cnt <= hold_cnt + 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        sched_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (rate_queue.size() == 0)
                report_mismatch("unexpected result", 64'(rate), 64'd0);
            else
            begin
                e = rate_queue.pop_front();
                if (rate !== e.rate) report_mismatch("rate", 64'(rate), 64'(e.rate));
                if (position !== e.position)
                    report_mismatch("position", 64'(position), 64'(e.position));
                if (period !== e.period) report_mismatch("period", 64'(period), 64'(e.period));
                if (epoch_now !== e.epoch_now)
                    report_mismatch("epoch_now", 64'(epoch_now), 64'(e.epoch_now));
                if (saturated !== e.saturated)
                    report_mismatch("saturated", 64'(saturated), 64'(e.saturated));
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cosine_restart_rate_schedule_unit: mismatch");
            $finish;
        end
    end

    row_t rows[$];

    task automatic add_row(row_kind_t k, logic [3:0] i, logic [31:0] d, logic md,
                           logic [31:0] t, sched_out_t kn);
        row_t r;
        r.kind = k; r.idx = i; r.data = d; r.mode = md; r.target = t; r.known = kn;
        rows.push_back(r);
    endtask

    initial
    begin
        sched_out_t z;
        logic [31:0] sv [5];
        z = '0;
        fill_cos_table();
        model_reset();

        // Directed table. Known rows: jump to 0 gives the start rate.
        add_row(ROW_STEP_KNOWN, 0, 0, 1'b1, 32'h0, '{32'h01000000, 0, 24'd10, 0, 1'b0});
        add_row(ROW_STEP, 0, 0, 1'b0, 0, z);
        add_row(ROW_STEP, 0, 0, 1'b1, 32'hFFFFFFFF, z);
        add_row(ROW_STEP, 0, 0, 1'b0, 32'hFFFFFFFF, z);   // advance at epoch limit
        add_row(ROW_STEP, 0, 0, 1'b1, 32'h00000980, z);
        add_row(ROW_CFG, 4'(REG_PERIOD_GROWTH), 0, 0, 0, z);   // zero growth acts as one
        add_row(ROW_CFG, 4'(REG_BASE_PERIOD), 0, 0, 0, z);     // zero base acts as one
        add_row(ROW_STEP_KNOWN, 0, 0, 1'b1, 32'h0, '{32'h01000000, 0, 24'd1, 0, 1'b0});
        add_row(ROW_STEP, 0, 0, 1'b0, 0, z);
        add_row(ROW_CFG, 4'(REG_PERIOD_GROWTH), 31, 0, 0, z);  // above 16 acts as 16
        add_row(ROW_STEP, 0, 0, 1'b1, 32'hFFFFFFFF, z);        // length saturates
        add_row(ROW_CFG, 4'(REG_BASE_PERIOD), 32'hFFFFFF, 0, 0, z);
        add_row(ROW_STEP, 0, 0, 1'b0, 0, z);
        add_row(ROW_CFG, 4'(REG_START_RATE), 0, 0, 0, z);      // start below floor
        add_row(ROW_CFG, 4'(REG_FLOOR_RATE), 32'hFFFFFFFF, 0, 0, z);
        add_row(ROW_STEP_KNOWN, 0, 0, 1'b1, 32'h0,
                '{32'h0, 0, 24'hFFFFFF, 0, 1'b0});
        add_row(ROW_STEP, 0, 0, 1'b1, 32'h7FFFFF80, z);
        add_row(ROW_CFG, 4'd9, 32'h12345678, 0, 0, z);         // unused index ignored
        add_row(ROW_CFG, 4'(REG_START_RATE), 32'hFFFFFFFF, 0, 0, z);
        add_row(ROW_CFG, 4'(REG_FLOOR_RATE), 0, 0, 0, z);
        add_row(ROW_CFG, 4'(REG_BASE_PERIOD), 3, 0, 0, z);
        add_row(ROW_CFG, 4'(REG_PERIOD_GROWTH), 2, 0, 0, z);
        add_row(ROW_STEP, 0, 0, 1'b1, 32'h00001500, z);
        add_row(ROW_STEP, 0, 0, 1'b0, 0, z);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].data);
            else
                send_item(rows[i].mode, rows[i].target, rows[i].kind == ROW_STEP_KNOWN,
                          rows[i].known);
        end

        // Random phases; first and last use extreme settings
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: sv = '{32'hFFFFFFFF, 32'h0, 32'd1, 32'd16, 0};
                9: sv = '{32'h0, 32'hFFFFFFFF, 32'hFFFFFF, 32'd1, 0};
                default:
                    sv = '{$urandom(), $urandom(), 32'($urandom_range(1, 40)),
                           32'($urandom_range(0, 31)), 0};
            endcase
            if (ph == 5) sv[2] = $urandom();
            for (int r = 0; r < 4; r++) write_reg(4'(r), sv[r]);
            for (int n = 0; n < 50; n++)
            begin
                if (ph == 3 && n == 10) long_hold = 1'b1;
                if ($urandom_range(0, 2) == 0) send_item(1'b1, rand_target(), 0, z);
                else send_item(1'b0, $urandom(), 0, z);
            end
        end
        in_valid <= 1'b0;

        while (rate_queue.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("cosine_restart_rate_schedule_unit: match");
        else
            $display("cosine_restart_rate_schedule_unit: mismatch");
        $finish;
    end
endmodule
